### rtl/core/poc_pkg.sv
package poc_pkg;

  localparam int CITY_COUNT_DEF = 8;
  localparam int CITY_W         = 3;
  localparam int CITY_CODES     = 1 << CITY_W;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 8;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MARK_RD,
    S_MARK_WR,
    S_POS,
    S_SEG_WAIT,
    S_SCAN_WAIT,
    S_OUT
  } poc_state_t;

  typedef struct packed {
    logic load_item;
    logic mark_set;
    logic put_zero;
    logic put_fp;
    logic put_sp;
    logic put_bad;
    logic skip;
    logic advance;
  } poc_cmd_t;

  typedef struct packed {
    logic seg_last;
    logic pos_zero;
    logic pos_in_seg;
    logic scan_done;
    logic sp_marked;
    logic pos_last;
    logic out_taken;
  } poc_status_t;

endpackage

### rtl/core/poc_ram.sv
module poc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/core/poc_ctrl.sv
module poc_ctrl import poc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tlast,
  output logic        in_tready,
  input  poc_status_t status,
  output poc_cmd_t    cmd
);

  poc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = S_MARK_RD;
        end
      end
      // ram read of the segment city is in flight
      S_MARK_RD: begin
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_set = 1'b1;
        state_nxt    = status.seg_last ? S_POS : S_MARK_RD;
      end
      S_POS: begin
        if (status.pos_zero) begin
          cmd.put_zero = 1'b1;
          state_nxt    = S_OUT;
        end else if (status.pos_in_seg) begin
          state_nxt = S_SEG_WAIT;
        end else if (status.scan_done) begin
          cmd.put_bad = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_SEG_WAIT: begin
        cmd.put_fp = 1'b1;
        state_nxt  = S_OUT;
      end
      S_SCAN_WAIT: begin
        if (status.sp_marked) begin
          cmd.skip  = 1'b1;
          state_nxt = S_POS;
        end else begin
          cmd.put_sp = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_taken) begin
          cmd.advance = 1'b1;
          state_nxt   = status.pos_last ? S_LOAD : S_POS;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

### rtl/core/poc_dp.sv
module poc_dp import poc_pkg::*; #(
  parameter int CITY_COUNT = CITY_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  input  logic                    in_tlast,
  input  poc_cmd_t                cmd,
  output poc_status_t             status,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic                    out_tlast,
  output logic                    out_tuser
);

  localparam int AW = $clog2(CITY_COUNT);
  localparam int PW = $clog2(CITY_COUNT + 1);
  localparam int WW = (PW > CITY_W) ? PW : CITY_W;
  localparam logic [WW-1:0] MAX_CUT = WW'(CITY_COUNT - 1);
  localparam logic [PW-1:0] LAST_POS = PW'(CITY_COUNT - 1);
  localparam logic [PW-1:0] N_POS = PW'(CITY_COUNT);

  logic [CITY_W-1:0] first_city, second_city, cut_a, cut_b;
  logic [PW-1:0]     lo_nxt, hi_nxt, cut_a_c, cut_b_c;
  logic [PW-1:0]     load_pos_r, pos_r, fill_ptr_r, lo_r, hi_r;
  logic [CITY_CODES-1:0] marks_r;
  logic [CITY_W-1:0] fp_rd, sp_rd;
  logic              store_we;
  logic              out_valid_r, out_last_r, out_bad_r;
  logic [CITY_W-1:0] out_city_r;
  logic              put_any;

  assign first_city  = in_tdata[CITY_W-1:0];
  assign second_city = in_tdata[2*CITY_W-1:CITY_W];
  assign cut_a       = in_tdata[3*CITY_W-1:2*CITY_W];
  assign cut_b       = in_tdata[4*CITY_W-1:3*CITY_W];

  function automatic logic [PW-1:0] clamp_cut(input logic [CITY_W-1:0] cut);
    logic [WW-1:0] v;
    v = WW'(cut);
    if (v == '0) begin
      v = WW'(1);
    end else if (v > MAX_CUT) begin
      v = MAX_CUT;
    end
    return PW'(v);
  endfunction

  assign cut_a_c = clamp_cut(cut_a);
  assign cut_b_c = clamp_cut(cut_b);
  assign lo_nxt  = (cut_a_c > cut_b_c) ? cut_b_c : cut_a_c;
  assign hi_nxt  = (cut_a_c > cut_b_c) ? cut_a_c : cut_b_c;

  assign store_we = cmd.load_item && (load_pos_r < N_POS);

  poc_ram #(.WIDTH(CITY_W), .DEPTH(CITY_COUNT)) u_first_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (load_pos_r[AW-1:0]),
    .wdata (first_city),
    .raddr (pos_r[AW-1:0]),
    .rdata (fp_rd)
  );

  poc_ram #(.WIDTH(CITY_W), .DEPTH(CITY_COUNT)) u_second_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (load_pos_r[AW-1:0]),
    .wdata (second_city),
    .raddr (fill_ptr_r[AW-1:0]),
    .rdata (sp_rd)
  );

  assign put_any = cmd.put_zero || cmd.put_fp || cmd.put_sp || cmd.put_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r  <= '0;
      pos_r       <= '0;
      fill_ptr_r  <= PW'(1);
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (store_we) begin
        load_pos_r <= load_pos_r + PW'(1);
      end
      if (cmd.load_item && in_tlast) begin
        marks_r    <= '0;
        pos_r      <= lo_nxt;
        fill_ptr_r <= PW'(1);
      end
      if (cmd.mark_set) begin
        marks_r[fp_rd] <= 1'b1;
        // segment fully marked, start emitting from position zero
        pos_r <= status.seg_last ? '0 : pos_r + PW'(1);
      end
      if (cmd.skip) begin
        fill_ptr_r <= fill_ptr_r + PW'(1);
      end
      if (cmd.put_sp) begin
        marks_r[sp_rd] <= 1'b1;
        fill_ptr_r     <= fill_ptr_r + PW'(1);
      end
      if (put_any) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.advance) begin
        pos_r <= pos_r + PW'(1);
        if (status.pos_last) begin
          load_pos_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item && in_tlast) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (put_any) begin
      out_last_r <= (pos_r == LAST_POS);
      out_bad_r  <= cmd.put_bad;
      if (cmd.put_fp) begin
        out_city_r <= fp_rd;
      end else if (cmd.put_sp) begin
        out_city_r <= sp_rd;
      end else begin
        out_city_r <= '0;
      end
    end
  end

  always_comb begin
    status.seg_last   = (pos_r == hi_r);
    status.pos_zero   = (pos_r == '0);
    status.pos_in_seg = (pos_r >= lo_r) && (pos_r <= hi_r);
    status.scan_done  = (fill_ptr_r >= N_POS);
    status.sp_marked  = marks_r[sp_rd];
    status.pos_last   = (pos_r == LAST_POS);
    status.out_taken  = out_valid_r && out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CITY_W){1'b0}}, out_city_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_ptr_r <= N_POS)
    else $error("fill pointer beyond parent length");
  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_pos_r <= N_POS)
    else $error("load position beyond parent length");
  a_bad_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> fill_ptr_r >= N_POS)
    else $error("bad flag without an exhausted scan");
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> pos_r == LAST_POS)
    else $error("last flag away from the final position");
`endif

endmodule

### rtl/core/permutation_order_crossover.sv
// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     tdata: parents, cuts; tlast: last position
// out_     out  out_tvalid / out_tready   tdata: child city; tlast: last; tuser: bad
//
// loading takes one parent position per cycle, in_tready is high only while loading
// a final item starts the burst: each segment city is read, then marked used; each
// child position takes S_POS, a read wait unless zero or bad, and S_OUT, plus S_SCAN_WAIT
// and S_POS per skipped parent-two probe, all bound by one registered read port per ram
// the burst of CITY_COUNT results goes out through one output register,
// a stall on out_tready holds the burst and no input is taken until it ends
// rst_n is synchronous, active low; parent stores are not cleared
module permutation_order_crossover import poc_pkg::*; #(
  parameter int CITY_COUNT = CITY_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // first_parent_city, second_parent_city, cut_start, cut_end, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // child_city, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // bad_input
  output logic                   out_tuser
);

  poc_cmd_t    cmd;
  poc_status_t status;

  poc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  poc_dp #(.CITY_COUNT(CITY_COUNT)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### tb/sv/permutation_order_crossover_tb.sv
`timescale 1ns / 1ps

module permutation_order_crossover_tb;
  import poc_pkg::*;

  localparam int N_CITIES     = CITY_COUNT_DEF;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_CYCLES = 100;

  typedef logic [CITY_W-1:0] city_t;
  typedef logic [N_CITIES-1:0][CITY_W-1:0] tour_t;

  typedef struct packed {
    city_t p1_city;
    city_t p2_city;
    city_t cut_a;
    city_t cut_b;
    logic  is_last;
  } position_t;

  typedef struct packed {
    city_t city;
    logic  last;
    logic  bad;
  } child_pos_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // first_parent_city, second_parent_city, cut_start, cut_end, zero fill
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // child_city, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  // bad_input
  logic                   out_tuser;

  position_t  pending[$];
  child_pos_t child_fifo[$];
  position_t  next_item;

  city_t p1_mem[N_CITIES];
  city_t p2_mem[N_CITIES];
  int    load_pos = 0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_go       = 1'b0;
  bit  hold_off      = 1'b0;
  int  mismatches    = 0;
  int  cycle_cnt     = 0;

  permutation_order_crossover #(
    .CITY_COUNT(N_CITIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_cut(city_t v);
    if (v < 1) return 1;
    if (v > N_CITIES - 1) return N_CITIES - 1;
    return int'(v);
  endfunction

  // stores one parent position and, on the final one, builds the whole child
  function automatic void absorb_position(position_t it);
    int                    lo;
    int                    hi;
    int                    tmp;
    int                    fill;
    logic [CITY_CODES-1:0] taken;
    child_pos_t            r;
    if (load_pos < N_CITIES) begin
      p1_mem[load_pos] = it.p1_city;
      p2_mem[load_pos] = it.p2_city;
      load_pos++;
    end
    if (!it.is_last) return;
    lo = clamp_cut(it.cut_a);
    hi = clamp_cut(it.cut_b);
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    taken = '0;
    for (int p = lo; p <= hi; p++) taken[p1_mem[p]] = 1'b1;
    fill = 1;
    for (int p = 0; p < N_CITIES; p++) begin
      r.last = (p == N_CITIES - 1);
      r.bad  = 1'b0;
      if (p == 0) begin
        // city 0 goes here without being marked used
        r.city = '0;
      end else if (p >= lo && p <= hi) begin
        r.city = p1_mem[p];
      end else begin
        while (fill < N_CITIES && taken[p2_mem[fill]]) fill++;
        if (fill >= N_CITIES) begin
          r.city = '0;
          r.bad  = 1'b1;
        end else begin
          r.city = p2_mem[fill];
          taken[r.city] = 1'b1;
        end
      end
      child_fifo.push_back(r);
    end
    load_pos = 0;
  endfunction

  function automatic tour_t random_tour(bit pin_zero);
    tour_t t;
    city_t c;
    int    j;
    int    first;
    for (int i = 0; i < N_CITIES; i++) t[i] = city_t'(i);
    first = pin_zero ? 1 : 0;
    for (int i = N_CITIES - 1; i > first; i--) begin
      j    = $urandom_range(i, first);
      c    = t[i];
      t[i] = t[j];
      t[j] = c;
    end
    return t;
  endfunction

  // positions past the store size carry random cities, cuts only matter on the last one
  task automatic queue_pair(tour_t a, tour_t b, int n_items, city_t cut_a, city_t cut_b);
    position_t it;
    for (int i = 0; i < n_items; i++) begin
      it.p1_city = (i < N_CITIES) ? a[i] : city_t'($urandom);
      it.p2_city = (i < N_CITIES) ? b[i] : city_t'($urandom);
      it.is_last = (i == n_items - 1);
      it.cut_a   = it.is_last ? cut_a : city_t'($urandom);
      it.cut_b   = it.is_last ? cut_b : city_t'($urandom);
      pending.push_back(it);
    end
  endtask

  task automatic queue_random_sets(int target);
    int    queued;
    int    n;
    int    kind;
    tour_t a;
    tour_t b;
    queued = 0;
    while (queued < target) begin
      kind = $urandom_range(99);
      n    = N_CITIES;
      a    = random_tour(kind < 60);
      b    = random_tour(kind < 60);
      if (kind >= 70 && kind < 80) begin
        n = $urandom_range(N_CITIES - 1, 1);
      end else if (kind >= 80 && kind < 88) begin
        n = $urandom_range(N_CITIES + 3, N_CITIES + 1);
      end else if (kind >= 88 && kind < 94) begin
        // one random city written into parent two, which may duplicate another
        b[$urandom_range(N_CITIES - 1, 1)] = city_t'($urandom);
      end else if (kind >= 94) begin
        for (int i = 0; i < N_CITIES; i++) begin
          a[i] = city_t'($urandom);
          b[i] = city_t'($urandom);
        end
      end
      queue_pair(a, b, n, city_t'($urandom), city_t'($urandom));
      queued += n;
    end
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_tvalid || child_fifo.size() != 0) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(IN_TDATA_W - 4 * CITY_W){1'b0}}, next_item.cut_b, next_item.cut_a,
                      next_item.p2_city, next_item.p1_city};
        in_tlast  <= next_item.is_last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      absorb_position(position_t'({in_tdata[CITY_W-1:0], in_tdata[2*CITY_W-1:CITY_W],
                                   in_tdata[3*CITY_W-1:2*CITY_W],
                                   in_tdata[4*CITY_W-1:3*CITY_W], in_tlast}));
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : child_check
    child_pos_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (child_fifo.size() == 0) begin
        $error("child_city %0d arrived with no transaction expected", out_tdata[CITY_W-1:0]);
        mismatches++;
      end else begin
        want = child_fifo.pop_front();
        if (out_tdata[CITY_W-1:0] !== want.city) begin
          $error("child_city: expected %0d, got %0d", want.city, out_tdata[CITY_W-1:0]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("child_last: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
        if (out_tuser !== want.bad) begin
          $error("bad_input: expected %0d, got %0d", want.bad, out_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** permutation_order_crossover: FAILED **");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 46;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // full first set so every store entry is written before any short set
    queue_pair(random_tour(1'b1), random_tour(1'b1), N_CITIES, 3'd2, 3'd5);
    // lone final item, both cuts below range
    queue_pair('1, '1, 1, 3'd0, 3'd0);
    // lone final item, cuts given high to low
    queue_pair('0, '0, 1, 3'd7, 3'd1);
    // one item too many, all cities equal so the scan runs dry
    queue_pair('1, '1, N_CITIES + 1, 3'd3, 3'd4);
    // city 0 free to sit anywhere in both parents, short set
    queue_pair(random_tour(1'b0), random_tour(1'b0), 5, 3'd7, 3'd6);
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 11;
    queue_random_sets(218);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_sets(218);
    hold_go = 1'b1;
    wait_drained();

    repeat (QUIET_CYCLES) @(posedge clk);
    if (mismatches == 0 && child_fifo.size() == 0) begin
      $display("** permutation_order_crossover: PASSED **");
    end else begin
      $display("** permutation_order_crossover: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/poc_pkg.sv
rtl/core/poc_ram.sv
rtl/core/poc_ctrl.sv
rtl/core/poc_dp.sv
rtl/core/permutation_order_crossover.sv
tb/sv/permutation_order_crossover_tb.sv
